/* hw/rtl/wrt_pkg.sv */
// Shared types and constants for the word range tokenizer.
// No dependencies; imported by every module of the block.
package wrt_pkg;

  // Default text capacity in code units.
  localparam longint unsigned WRT_MAX_TEXT_UNITS = 64'd65536;

  // Field widths fixed by the stream format.
  localparam int CODE_W  = 16;
  localparam int START_W = 16;
  localparam int LEN_W   = 17;

  // Joiner code units.
  localparam logic [CODE_W-1:0] APOSTROPHE_UNIT = 16'h0027;
  localparam logic [CODE_W-1:0] HYPHEN_UNIT     = 16'h002D;

  // One finished word as it travels from the front end to the back end.
  // Both bounds are kept modulo 2**LEN_W, which is enough for the wrapped
  // start and length on the output.
  typedef struct packed {
    logic [LEN_W-1:0] span_end;
    logic [LEN_W-1:0] span_begin;
  } word_span_t;

endpackage

/* hw/rtl/wrt_front.sv */
// Front end of the word range tokenizer: accepts code units, tracks words.
// Depends on wrt_pkg; pushes finished word spans into wrt_queue.
module wrt_front #(
  parameter longint unsigned MAX_TEXT_UNITS = wrt_pkg::WRT_MAX_TEXT_UNITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [wrt_pkg::CODE_W-1:0] code_unit,
  input  logic                       is_alnum,
  input  logic                       last_unit,
  output logic                       push,
  output wrt_pkg::word_span_t        push_span
);
  import wrt_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT_UNITS + 64'd1);
  localparam logic [POS_W-1:0] CAP = MAX_TEXT_UNITS[POS_W-1:0];
  localparam logic [POS_W-1:0] ONE = {{(POS_W-1){1'b0}}, 1'b1};

  logic             inside_word, inside_word_next;
  logic             joiner_pending, joiner_pending_next;
  logic [POS_W-1:0] current_word_start, current_word_start_next;
  logic [POS_W-1:0] position, position_next;
  logic             emit;
  logic [POS_W-1:0] emit_end;
  logic [POS_W-1:0] emit_begin;
  logic             joiner;
  logic [POS_W+LEN_W-1:0] end_ext, begin_ext;

  assign joiner = (code_unit == APOSTROPHE_UNIT) || (code_unit == HYPHEN_UNIT);

  always_comb begin
    inside_word_next        = inside_word;
    joiner_pending_next     = joiner_pending;
    current_word_start_next = current_word_start;
    position_next           = position;
    emit                    = 1'b0;
    emit_end                = position;
    emit_begin              = current_word_start;
    if (position < CAP) begin
      if (is_alnum) begin
        if (!inside_word) begin
          inside_word_next        = 1'b1;
          current_word_start_next = position;
        end
        joiner_pending_next = 1'b0;
      end else if (joiner) begin
        if (inside_word) begin
          if (joiner_pending) begin
            // Two joiners in a row: the word ends before the first one.
            emit                = 1'b1;
            emit_end            = position - ONE;
            inside_word_next    = 1'b0;
            joiner_pending_next = 1'b0;
          end else begin
            joiner_pending_next = 1'b1;
          end
        end
      end else if (inside_word) begin
        emit                = 1'b1;
        emit_end            = position - {{(POS_W-1){1'b0}}, joiner_pending};
        inside_word_next    = 1'b0;
        joiner_pending_next = 1'b0;
      end
      position_next = position + ONE;
    end
    if (last_unit) begin
      // The start of a word that this beat opens is only known here.
      emit_begin = current_word_start_next;
      if (inside_word_next && !emit) begin
        emit     = 1'b1;
        emit_end = position_next - {{(POS_W-1){1'b0}}, joiner_pending_next};
      end
      inside_word_next        = 1'b0;
      joiner_pending_next     = 1'b0;
      current_word_start_next = '0;
      position_next           = '0;
    end
  end

  // Bounds wrap to the span width; zero extension covers small capacities.
  assign end_ext   = {{LEN_W{1'b0}}, emit_end};
  assign begin_ext = {{LEN_W{1'b0}}, emit_begin};

  assign push                 = accept && emit;
  assign push_span.span_end   = end_ext[LEN_W-1:0];
  assign push_span.span_begin = begin_ext[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word        <= 1'b0;
      joiner_pending     <= 1'b0;
      current_word_start <= '0;
      position           <= '0;
    end else if (accept) begin
      inside_word        <= inside_word_next;
      joiner_pending     <= joiner_pending_next;
      current_word_start <= current_word_start_next;
      position           <= position_next;
    end
  end

endmodule

/* hw/rtl/wrt_queue.sv */
// Two-entry queue of word spans between the front and back ends.
// Depends on wrt_pkg for the span type.
module wrt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wrt_pkg::word_span_t push_span,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output wrt_pkg::word_span_t head_span
);
  import wrt_pkg::*;

  word_span_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push, do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_span = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/wrt_back.sv */
// Back end of the word range tokenizer: turns spans into start and length.
// Depends on wrt_pkg; drains wrt_queue into a registered output beat.
module wrt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        span_valid,
  input  wrt_pkg::word_span_t         span,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wrt_pkg::START_W-1:0] word_start,
  output logic [wrt_pkg::LEN_W-1:0]   word_length
);
  import wrt_pkg::*;

  logic load;

  assign load = span_valid && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_start  <= span.span_begin[START_W-1:0];
      word_length <= span.span_end - span.span_begin;
    end
  end

endmodule

/* hw/rtl/word_range_tokenizer.sv */
// Word range tokenizer: one code unit per beat in, one word range per beat out.
// A word's range passes through the span queue and is registered in the back end before it appears on the output.
// Throughput: one input beat per cycle; the front end stalls only when the two-entry
// span queue is full, which happens only when the output side is backpressured.
// Reset (rst, synchronous, active high) clears word state, position, the queue and the output valid flag.
// Depends on wrt_pkg, wrt_front, wrt_queue and wrt_back.
module word_range_tokenizer #(
  parameter longint unsigned MAX_TEXT_UNITS = wrt_pkg::WRT_MAX_TEXT_UNITS
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream of code units.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tuser,   // [0] is_alnum
  input  logic        s_axis_tlast,   // last_unit
  // Output stream of word ranges.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [15:0] word_start, [32:16] word_length, rest zero
);
  import wrt_pkg::*;

  logic                accept;
  logic                push;
  word_span_t          push_span;
  logic                queue_full;
  logic                queue_not_empty;
  word_span_t          head_span;
  logic                pop;
  logic [START_W-1:0]  word_start;
  logic [LEN_W-1:0]    word_length;

  // The front end takes a beat whenever the queue can hold the span it may produce.
  // Beats that close no word pass through the front end without touching the queue.
  assign s_axis_tready = !queue_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wrt_front #(
    .MAX_TEXT_UNITS (MAX_TEXT_UNITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_unit (s_axis_tdata[CODE_W-1:0]),
    .is_alnum  (s_axis_tuser),
    .last_unit (s_axis_tlast),
    .push      (push),
    .push_span (push_span)
  );

  // The queue decouples the front end from output backpressure.
  wrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_span (push_span),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_span (head_span)
  );

  // The back end computes the length and holds the output beat until it is taken.
  wrt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .span_valid  (queue_not_empty),
    .span        (head_span),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .word_start  (word_start),
    .word_length (word_length)
  );

  assign m_axis_tdata = {7'b0, word_length, word_start};

endmodule
